// ===== hw/rtl/rrpt_pkg.sv =====
// Shared types and constants for the round-robin process table unit.
// Used by the controller, the datapath and the top level; no dependencies.
package rrpt_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int ID_W       = 32;
  localparam int TAG_W      = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int CNT_OUT_W  = 5;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_START  = 2'd1,
    CMD_YIELD  = 2'd2,
    CMD_EXIT   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_NOTHING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2
  } slot_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic read;
    logic emit;
  } rrpt_ctrl_t;

endpackage

// ===== hw/rtl/rrpt_ctrl.sv =====
// Controller state machine of the round-robin process table unit.
// Sequences accept, execute, table read and result strobe; uses rrpt_pkg.
module rrpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output rrpt_pkg::rrpt_ctrl_t ctrl
);
  import rrpt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } fsm_state_t;

  fsm_state_t state_r;
  logic       busy_r;
  logic       emit_r;
  logic       accept;

  assign accept = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      emit_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE, S_DONE: begin
          emit_r <= 1'b0;
          if (accept) begin
            state_r <= S_EXEC;
            busy_r  <= 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EXEC: begin
          state_r <= S_READ;
        end
        S_READ: begin
          state_r <= S_DONE;
          busy_r  <= 1'b0;
          emit_r  <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
          emit_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy        = busy_r;
  assign ctrl.accept = accept;
  assign ctrl.exec   = (state_r == S_EXEC);
  assign ctrl.read   = (state_r == S_READ);
  assign ctrl.emit   = emit_r;

endmodule

// ===== hw/rtl/rrpt_dp.sv =====
// Datapath of the round-robin process table unit: slot states, id and tag
// memories, slot searches and result assembly. Driven by rrpt_ctrl; uses rrpt_pkg.
module rrpt_dp #(
  parameter int SLOTS = rrpt_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rrpt_pkg::rrpt_ctrl_t            ctrl,
  input  logic [1:0]                      in_cmd,
  input  logic [rrpt_pkg::TAG_W-1:0]      in_task_tag,
  input  logic [3:0]                      in_probe_slot,
  input  logic                            cfg_we,
  input  logic [rrpt_pkg::TAG_W-1:0]      cfg_wdata,
  output logic [1:0]                      out_status,
  output logic [rrpt_pkg::SLOT_OUT_W-1:0] out_new_slot,
  output logic                            out_switched,
  output logic                            out_current_valid,
  output logic [rrpt_pkg::SLOT_OUT_W-1:0] out_current_slot,
  output logic [rrpt_pkg::ID_W-1:0]       out_current_pid,
  output logic [rrpt_pkg::TAG_W-1:0]      out_current_tag,
  output logic [rrpt_pkg::CNT_OUT_W-1:0]  out_process_count,
  output logic [rrpt_pkg::ID_W-1:0]       out_probe_pid,
  output logic [1:0]                      out_probe_state
);
  import rrpt_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic          hit;
    logic [IW-1:0] idx;
  } pick_t;

  function automatic pick_t lowest(input logic [SLOTS-1:0] v);
    pick_t p;
    p.hit = 1'b0;
    p.idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p.hit = 1'b1;
        p.idx = IW'(i);
      end
    end
    return p;
  endfunction

  slot_state_t        st_r [SLOTS];
  slot_state_t        st_nxt [SLOTS];
  logic [IW-1:0]      run_slot_r, run_slot_nxt;
  logic               run_valid_r, run_valid_nxt;
  logic               started_r, started_nxt;
  logic [ID_W-1:0]    next_id_r, next_id_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [TAG_W-1:0]   idle_tag_r;

  cmd_t               cmd_r;
  logic [TAG_W-1:0]   tag_r;
  logic [3:0]         probe_r;
  status_t            status_r, status_nxt;
  logic [IW-1:0]      new_slot_r, new_slot_nxt;
  logic               old_valid_r;
  logic [IW-1:0]      old_slot_r;

  logic [ID_W-1:0]    pid_mem [SLOTS];
  logic [TAG_W-1:0]   tag_mem [SLOTS];
  logic [ID_W-1:0]    old_pid_rd_r, cur_pid_rd_r, probe_pid_rd_r;
  logic [TAG_W-1:0]   cur_tag_rd_r;

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [TAG_W-1:0]   wr_tag;

  logic [SLOTS-1:0]   free_v, ready_v, live_v, cur_v, above_v;
  pick_t              p_free, p_ready, p_hi, p_any, p_yield, p_live, p_free_x;

  logic [IW+3:0]      probe_wide;
  logic [IW-1:0]      probe_addr;
  logic               probe_in;
  logic [IW+3:0]      run_wide, new_wide;
  logic [CW+4:0]      cnt_wide;
  logic [ID_W-1:0]    cur_pid, old_pid;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_v[i]  = (st_r[i] == ST_UNUSED);
      ready_v[i] = (st_r[i] == ST_READY);
      live_v[i]  = (st_r[i] != ST_UNUSED);
      cur_v[i]   = (IW'(i) == run_slot_r);
      above_v[i] = (IW'(i) > run_slot_r);
    end
  end

  assign p_free   = lowest(free_v);
  assign p_ready  = lowest(ready_v);
  assign p_hi     = lowest(ready_v & ~cur_v & above_v);
  assign p_any    = lowest(ready_v & ~cur_v);
  assign p_yield  = p_hi.hit ? p_hi : p_any;
  assign p_live   = lowest(live_v & ~cur_v);
  assign p_free_x = lowest(free_v | cur_v);

  always_comb begin
    st_nxt        = st_r;
    run_slot_nxt  = run_slot_r;
    run_valid_nxt = run_valid_r;
    started_nxt   = started_r;
    next_id_nxt   = next_id_r;
    count_nxt     = count_r;
    status_nxt    = STAT_DONE;
    new_slot_nxt  = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_tag        = idle_tag_r;
    case (cmd_r)
      CMD_CREATE: begin
        if (p_free.hit) begin
          wr_en               = 1'b1;
          wr_addr             = p_free.idx;
          wr_tag              = tag_r;
          st_nxt[p_free.idx]  = ST_READY;
          next_id_nxt         = next_id_r + 1'b1;
          count_nxt           = count_r + 1'b1;
          new_slot_nxt        = p_free.idx;
        end else begin
          status_nxt = STAT_NO_FREE;
        end
      end
      CMD_START: begin
        if (started_r) begin
          status_nxt = STAT_IGNORED;
        end else if (p_ready.hit) begin
          st_nxt[p_ready.idx] = ST_RUNNING;
          run_slot_nxt        = p_ready.idx;
          run_valid_nxt       = 1'b1;
          started_nxt         = 1'b1;
        end else if (p_free.hit) begin
          wr_en               = 1'b1;
          wr_addr             = p_free.idx;
          st_nxt[p_free.idx]  = ST_RUNNING;
          next_id_nxt         = next_id_r + 1'b1;
          count_nxt           = count_r + 1'b1;
          run_slot_nxt        = p_free.idx;
          run_valid_nxt       = 1'b1;
          started_nxt         = 1'b1;
        end else begin
          status_nxt = STAT_NOTHING;
        end
      end
      CMD_YIELD: begin
        if (!started_r || !run_valid_r) begin
          status_nxt = STAT_IGNORED;
        end else if (p_yield.hit) begin
          if (st_r[run_slot_r] == ST_RUNNING) begin
            st_nxt[run_slot_r] = ST_READY;
          end
          st_nxt[p_yield.idx] = ST_RUNNING;
          run_slot_nxt        = p_yield.idx;
        end else begin
          st_nxt[run_slot_r] = ST_RUNNING;
        end
      end
      default: begin
        if (!run_valid_r) begin
          status_nxt = STAT_IGNORED;
        end else begin
          st_nxt[run_slot_r] = ST_UNUSED;
          if (p_live.hit) begin
            st_nxt[p_live.idx] = ST_RUNNING;
            run_slot_nxt       = p_live.idx;
            count_nxt          = count_r - 1'b1;
          end else if (p_free_x.hit) begin
            wr_en                = 1'b1;
            wr_addr              = p_free_x.idx;
            st_nxt[p_free_x.idx] = ST_RUNNING;
            next_id_nxt          = next_id_r + 1'b1;
            run_slot_nxt         = p_free_x.idx;
          end else begin
            started_nxt   = 1'b0;
            run_valid_nxt = 1'b0;
            run_slot_nxt  = '0;
            count_nxt     = count_r - 1'b1;
            status_nxt    = STAT_NOTHING;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_r[i] <= ST_UNUSED;
      end
      run_slot_r  <= '0;
      run_valid_r <= 1'b0;
      started_r   <= 1'b0;
      next_id_r   <= ID_W'(1);
      count_r     <= '0;
      idle_tag_r  <= '0;
    end else begin
      if (cfg_we) begin
        idle_tag_r <= cfg_wdata;
      end
      if (ctrl.exec) begin
        st_r        <= st_nxt;
        run_slot_r  <= run_slot_nxt;
        run_valid_r <= run_valid_nxt;
        started_r   <= started_nxt;
        next_id_r   <= next_id_nxt;
        count_r     <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_r   <= cmd_t'(in_cmd);
      tag_r   <= in_task_tag;
      probe_r <= in_probe_slot;
    end
    if (ctrl.exec) begin
      status_r    <= status_nxt;
      new_slot_r  <= new_slot_nxt;
      old_valid_r <= run_valid_r;
      old_slot_r  <= run_slot_r;
    end
  end

  assign probe_wide = (IW + 4)'(probe_r);
  assign probe_addr = probe_wide[IW-1:0];
  assign probe_in   = (32'(probe_r) < 32'(SLOTS));

  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      pid_mem[wr_addr] <= next_id_r;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      old_pid_rd_r <= pid_mem[run_slot_r];
    end
    if (ctrl.read) begin
      cur_pid_rd_r   <= pid_mem[run_slot_r];
      probe_pid_rd_r <= pid_mem[probe_addr];
      cur_tag_rd_r   <= tag_mem[run_slot_r];
    end
  end

  assign cur_pid  = run_valid_r ? cur_pid_rd_r : '0;
  assign old_pid  = old_valid_r ? old_pid_rd_r : '0;
  assign run_wide = (IW + 4)'(run_valid_r ? run_slot_r : '0);
  assign new_wide = (IW + 4)'(new_slot_r);
  assign cnt_wide = (CW + 5)'(count_r);

  assign out_status        = status_r;
  assign out_new_slot      = new_wide[SLOT_OUT_W-1:0];
  assign out_switched      = (old_valid_r != run_valid_r) ||
                             (run_valid_r && (old_slot_r != run_slot_r)) ||
                             (old_pid != cur_pid);
  assign out_current_valid = run_valid_r;
  assign out_current_slot  = run_wide[SLOT_OUT_W-1:0];
  assign out_current_pid   = cur_pid;
  assign out_current_tag   = run_valid_r ? cur_tag_rd_r : '0;
  assign out_process_count = cnt_wide[CNT_OUT_W-1:0];
  assign out_probe_pid     = (probe_in && (st_r[probe_addr] != ST_UNUSED)) ?
                             probe_pid_rd_r : '0;
  assign out_probe_state   = probe_in ? 2'(st_r[probe_addr]) : 2'(ST_UNUSED);

endmodule

// ===== hw/rtl/round_robin_process_table_unit.sv =====
// Top level of the round-robin process table unit.
// Instantiates rrpt_ctrl and rrpt_dp; uses rrpt_pkg.
//
//   Channel  Ports                                  Handshake
//   input    in_cmd, in_task_tag, in_probe_slot     start high while busy low
//   result   out_status ... out_probe_state         out_valid for one cycle
//   config   cfg_wdata                              cfg_we high
//
// From acceptance a command updates the slot table, then reads the id and tag
// memories, then presents the result with the strobe. A new command may be
// accepted in the strobe cycle, but not before the last result is presented,
// so commands are not overlapped. Reset is synchronous and leaves all slots
// unused with the next id at one. The receiver cannot stall results.
module round_robin_process_table_unit #(
  parameter int SLOTS = rrpt_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_cmd,
  input  logic [rrpt_pkg::TAG_W-1:0]      in_task_tag,
  input  logic [3:0]                      in_probe_slot,
  input  logic                            cfg_we,
  input  logic [rrpt_pkg::TAG_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [rrpt_pkg::SLOT_OUT_W-1:0] out_new_slot,
  output logic                            out_switched,
  output logic                            out_current_valid,
  output logic [rrpt_pkg::SLOT_OUT_W-1:0] out_current_slot,
  output logic [rrpt_pkg::ID_W-1:0]       out_current_pid,
  output logic [rrpt_pkg::TAG_W-1:0]      out_current_tag,
  output logic [rrpt_pkg::CNT_OUT_W-1:0]  out_process_count,
  output logic [rrpt_pkg::ID_W-1:0]       out_probe_pid,
  output logic [1:0]                      out_probe_state
);
  import rrpt_pkg::*;

  rrpt_ctrl_t ctrl;

  rrpt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  rrpt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_cmd            (in_cmd),
    .in_task_tag       (in_task_tag),
    .in_probe_slot     (in_probe_slot),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_status        (out_status),
    .out_new_slot      (out_new_slot),
    .out_switched      (out_switched),
    .out_current_valid (out_current_valid),
    .out_current_slot  (out_current_slot),
    .out_current_pid   (out_current_pid),
    .out_current_tag   (out_current_tag),
    .out_process_count (out_process_count),
    .out_probe_pid     (out_probe_pid),
    .out_probe_state   (out_probe_state)
  );

  assign out_valid = ctrl.emit;

endmodule

// ===== hw/rtl/rrpt_checker.sv =====
// Port-level assertions for the round-robin process table unit.
// Bound to round_robin_process_table_unit; depends on rrpt_pkg.
module rrpt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            out_current_valid,
  input logic [rrpt_pkg::SLOT_OUT_W-1:0] out_current_slot,
  input logic [rrpt_pkg::ID_W-1:0]       out_current_pid,
  input logic [rrpt_pkg::TAG_W-1:0]      out_current_tag
);
  import rrpt_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe missing three cycles after acceptance");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_no_current: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_current_valid) |->
      (out_current_slot == '0 && out_current_pid == '0 && out_current_tag == '0))
    else $error("current fields nonzero without a current slot");

endmodule

bind round_robin_process_table_unit rrpt_checker u_rrpt_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for round_robin_process_table_unit: random and directed scheduler
// commands, idle-tag writes between phases, and a transaction-level model of the slot table.
// Depends on rrpt_pkg and the RTL of the unit only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrpt_pkg::*;

  localparam int NSLOT = SLOTS_DEF;

  typedef enum logic [1:0] {
    ACT_CMD,
    ACT_CFG,
    ACT_DRAIN
  } action_kind_t;

  typedef struct packed {
    action_kind_t kind;
    cmd_t         cmd;
    logic [31:0]  data;
    logic [3:0]   probe;
  } pending_action_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  new_slot;
    logic        switched;
    logic        cur_valid;
    logic [3:0]  cur_slot;
    logic [31:0] cur_pid;
    logic [31:0] cur_tag;
    logic [4:0]  count;
    logic [31:0] probe_pid;
    slot_state_t probe_state;
  } proc_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = CMD_CREATE;
  logic [31:0] in_task_tag = '0;
  logic [3:0]  in_probe_slot = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_new_slot;
  logic        out_switched;
  logic        out_current_valid;
  logic [3:0]  out_current_slot;
  logic [31:0] out_current_pid;
  logic [31:0] out_current_tag;
  logic [4:0]  out_process_count;
  logic [31:0] out_probe_pid;
  logic [1:0]  out_probe_state;

  round_robin_process_table_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_task_tag      (in_task_tag),
    .in_probe_slot    (in_probe_slot),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_new_slot     (out_new_slot),
    .out_switched     (out_switched),
    .out_current_valid(out_current_valid),
    .out_current_slot (out_current_slot),
    .out_current_pid  (out_current_pid),
    .out_current_tag  (out_current_tag),
    .out_process_count(out_process_count),
    .out_probe_pid    (out_probe_pid),
    .out_probe_state  (out_probe_state)
  );

  pending_action_t command_queue[$];
  proc_report_t    expected_reports[$];

  slot_state_t tbl_state[NSLOT];
  logic [31:0] tbl_pid[NSLOT];
  logic [31:0] tbl_tag[NSLOT];
  logic [3:0]  run_slot = '0;
  logic        run_valid = 1'b0;
  logic [31:0] id_next = 32'd1;
  logic        sched_started = 1'b0;
  logic [31:0] model_idle_tag = '0;

  int total_cmds = 0;
  int accepted_cnt = 0;
  int mismatch_cnt = 0;
  int cfg_writes = 0;
  int idle_spawns = 0;
  int cmd_seen[4] = '{0, 0, 0, 0};
  int status_seen[4] = '{0, 0, 0, 0};
  int burst_left = 1;
  int gap_left = 0;

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_state[i] = ST_UNUSED;
      tbl_pid[i] = '0;
      tbl_tag[i] = '0;
    end
  end

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int lowest_in_state(slot_state_t st);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_state[i] == st) return i;
    return -1;
  endfunction

  function automatic int spawn_process(logic [31:0] tag);
    int s;
    s = lowest_in_state(ST_UNUSED);
    if (s < 0) return -1;
    tbl_pid[s] = id_next;
    id_next = id_next + 32'd1;
    tbl_state[s] = ST_READY;
    tbl_tag[s] = tag;
    return s;
  endfunction

  function automatic logic [31:0] running_pid();
    if (run_valid && tbl_state[run_slot] != ST_UNUSED) return tbl_pid[run_slot];
    return '0;
  endfunction

  function automatic proc_report_t table_model_step(cmd_t cmd, logic [31:0] tag,
                                                    logic [3:0] probe);
    proc_report_t r;
    logic        old_valid;
    logic [3:0]  old_slot;
    logic [31:0] old_pid;
    int          s;
    int          found;
    int          idx;
    int          live;
    r = '0;
    old_valid = run_valid;
    old_slot = run_slot;
    old_pid = running_pid();
    r.status = STAT_DONE;
    case (cmd)
      CMD_CREATE: begin
        s = spawn_process(tag);
        if (s < 0) r.status = STAT_NO_FREE;
        else r.new_slot = s[3:0];
      end
      CMD_START: begin
        if (sched_started) begin
          r.status = STAT_IGNORED;
        end else begin
          if (lowest_in_state(ST_READY) < 0) begin
            if (spawn_process(model_idle_tag) >= 0) idle_spawns++;
          end
          s = lowest_in_state(ST_READY);
          if (s < 0) begin
            r.status = STAT_NOTHING;
          end else begin
            run_slot = s[3:0];
            run_valid = 1'b1;
            tbl_state[s] = ST_RUNNING;
            sched_started = 1'b1;
          end
        end
      end
      CMD_YIELD: begin
        if (!sched_started || !run_valid) begin
          r.status = STAT_IGNORED;
        end else begin
          found = -1;
          if (tbl_state[run_slot] == ST_RUNNING) tbl_state[run_slot] = ST_READY;
          for (int i = 1; i <= NSLOT && found < 0; i++) begin
            idx = (int'(run_slot) + i) % NSLOT;
            if (tbl_state[idx] == ST_READY) found = idx;
          end
          if (found < 0 || found == int'(run_slot)) begin
            tbl_state[run_slot] = ST_RUNNING;
          end else begin
            run_slot = found[3:0];
            tbl_state[found] = ST_RUNNING;
          end
        end
      end
      default: begin
        if (!run_valid) begin
          r.status = STAT_IGNORED;
        end else begin
          tbl_state[run_slot] = ST_UNUSED;
          tbl_pid[run_slot] = '0;
          tbl_tag[run_slot] = '0;
          found = -1;
          for (int i = 0; i < NSLOT && found < 0; i++)
            if (tbl_state[i] != ST_UNUSED && i != int'(run_slot)) found = i;
          if (found < 0) begin
            found = spawn_process(model_idle_tag);
            if (found >= 0) idle_spawns++;
          end
          if (found < 0) begin
            sched_started = 1'b0;
            run_valid = 1'b0;
            run_slot = '0;
            r.status = STAT_NOTHING;
          end else begin
            run_slot = found[3:0];
            tbl_state[found] = ST_RUNNING;
          end
        end
      end
    endcase
    live = 0;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_state[i] != ST_UNUSED) live++;
    r.switched = (old_valid != run_valid) || (run_valid && old_slot != run_slot) ||
                 (old_pid != running_pid());
    r.cur_valid = run_valid;
    r.cur_slot = run_valid ? run_slot : 4'd0;
    r.cur_pid = running_pid();
    r.cur_tag = run_valid ? tbl_tag[run_slot] : 32'd0;
    r.count = live[4:0];
    r.probe_pid = (tbl_state[probe] != ST_UNUSED) ? tbl_pid[probe] : 32'd0;
    r.probe_state = tbl_state[probe];
    cmd_seen[cmd]++;
    status_seen[r.status]++;
    return r;
  endfunction

  function automatic string show_report(proc_report_t r);
    return $sformatf("st=%0d new=%0d sw=%0b cv=%0b cs=%0d pid=%h tag=%h cnt=%0d ppid=%h pst=%0d",
                     r.status, r.new_slot, r.switched, r.cur_valid, r.cur_slot, r.cur_pid,
                     r.cur_tag, r.count, r.probe_pid, r.probe_state);
  endfunction

  task automatic queue_cmd(cmd_t cmd, logic [31:0] tag, logic [3:0] probe);
    pending_action_t a;
    a.kind = ACT_CMD;
    a.cmd = cmd;
    a.data = tag;
    a.probe = probe;
    command_queue.push_back(a);
    total_cmds++;
  endtask

  task automatic queue_ctl(action_kind_t kind, logic [31:0] value);
    pending_action_t a;
    a.kind = kind;
    a.cmd = CMD_CREATE;
    a.data = value;
    a.probe = '0;
    command_queue.push_back(a);
  endtask

  function automatic logic [31:0] pick_tag();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t pick_cmd(int mode);
    int roll;
    int create_w;
    int yield_w;
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin create_w = 35; yield_w = 35; end
      1: begin create_w = 70; yield_w = 15; end
      default: begin create_w = 15; yield_w = 20; end
    endcase
    if (roll < 4) return CMD_START;
    if (roll < 4 + create_w) return CMD_CREATE;
    if (roll < 4 + create_w + yield_w) return CMD_YIELD;
    return CMD_EXIT;
  endfunction

  always @(posedge clk) begin : drive_proc
    pending_action_t act;
    logic            holding;
    logic            nxt_start;
    logic            nxt_we;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      holding = start;
      if (start && !busy) begin
        expected_reports.push_back(table_model_step(cmd_t'(in_cmd), in_task_tag, in_probe_slot));
        accepted_cnt++;
        holding = 1'b0;
      end
      if (cfg_we) begin
        model_idle_tag = cfg_wdata;
        cfg_writes++;
      end
      nxt_start = holding;
      nxt_we = 1'b0;
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (command_queue.size() > 0) begin
          act = command_queue[0];
          case (act.kind)
            ACT_CMD: begin
              act = command_queue.pop_front();
              in_cmd <= act.cmd;
              in_task_tag <= act.data;
              in_probe_slot <= act.probe;
              nxt_start = 1'b1;
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
              end
            end
            ACT_CFG: begin
              if (expected_reports.size() == 0) begin
                act = command_queue.pop_front();
                cfg_wdata <= act.data;
                nxt_we = 1'b1;
              end
            end
            default: begin
              if (expected_reports.size() == 0) act = command_queue.pop_front();
            end
          endcase
        end
      end
      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  always @(posedge clk) begin : check_proc
    proc_report_t want;
    proc_report_t got;
    if (rst_n && out_valid) begin
      got.status = status_t'(out_status);
      got.new_slot = out_new_slot;
      got.switched = out_switched;
      got.cur_valid = out_current_valid;
      got.cur_slot = out_current_slot;
      got.cur_pid = out_current_pid;
      got.cur_tag = out_current_tag;
      got.count = out_process_count;
      got.probe_pid = out_probe_pid;
      got.probe_state = slot_state_t'(out_probe_state);
      if (expected_reports.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result with no transaction outstanding: %s", $realtime,
                   show_report(got));
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: mismatch, expected %s", $realtime, show_report(want));
            $display("%0t:           actual   %s", $realtime, show_report(got));
          end
        end
      end
    end
  end

  initial begin
    int mode;
    int pause_at;
    queue_ctl(ACT_CFG, 32'hFFFF_FFFF);
    queue_cmd(CMD_YIELD, 32'h1234_5678, 4'd0);
    queue_cmd(CMD_EXIT, 32'h0000_0000, 4'd15);
    queue_cmd(CMD_START, 32'h0000_0000, 4'd0);
    queue_cmd(CMD_START, 32'hFFFF_FFFF, 4'd0);
    queue_cmd(CMD_YIELD, 32'h0000_0000, 4'd0);
    queue_cmd(CMD_CREATE, 32'h0000_0000, 4'd1);
    queue_cmd(CMD_CREATE, 32'hFFFF_FFFF, 4'd2);
    queue_cmd(CMD_CREATE, 32'hA5A5_5A5A, 4'd3);
    queue_cmd(CMD_YIELD, 32'h0000_0000, 4'd1);
    queue_cmd(CMD_YIELD, 32'h0000_0000, 4'd2);
    queue_cmd(CMD_YIELD, 32'h0000_0000, 4'd3);
    queue_cmd(CMD_YIELD, 32'h0000_0000, 4'd0);
    queue_cmd(CMD_EXIT, 32'h0000_0000, 4'd0);
    queue_cmd(CMD_EXIT, 32'h0000_0000, 4'd1);
    queue_ctl(ACT_CFG, 32'h0000_0000);
    queue_cmd(CMD_EXIT, 32'h0000_0000, 4'd2);
    queue_cmd(CMD_EXIT, 32'h0000_0000, 4'd3);
    queue_cmd(CMD_CREATE, 32'h5A5A_A5A5, 4'd15);
    for (int p = 0; p < 8; p++) begin
      mode = p % 3;
      case (p)
        2: queue_ctl(ACT_CFG, 32'hFFFF_FFFF);
        5: queue_ctl(ACT_CFG, 32'h0000_0000);
        default: queue_ctl(ACT_CFG, $urandom);
      endcase
      pause_at = $urandom_range(20, 200);
      for (int n = 0; n < 230; n++) begin
        if (n == pause_at) queue_ctl(ACT_DRAIN, '0);
        queue_cmd(pick_cmd(mode), pick_tag(), 4'($urandom_range(0, NSLOT - 1)));
      end
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_cnt < total_cmds || expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d transactions: %0d create, %0d start, %0d yield, %0d exit; %0d idle-tag writes.",
             accepted_cnt, cmd_seen[CMD_CREATE], cmd_seen[CMD_START], cmd_seen[CMD_YIELD],
             cmd_seen[CMD_EXIT], cfg_writes);
    $display("Outcomes: %0d done, %0d table full, %0d ignored; %0d idle processes spawned.",
             status_seen[STAT_DONE], status_seen[STAT_NO_FREE], status_seen[STAT_IGNORED],
             idle_spawns);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total.", mismatch_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d of %0d transactions accepted.", accepted_cnt, total_cmds);
    $display("Regression FAIL");
    $finish;
  end

endmodule
